>>> hw/rtl/wrpm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the windowed rms power meter
package wrpm_pkg;

    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int MAX_CHANNELS_DEF = 8;

    localparam int SUM_W    = 50;
    localparam int N_W      = 21;
    localparam int X_W      = 51;
    localparam int LOG_FRAC = 24;
    localparam int LOG_W    = 30;
    localparam int ROOT_W   = 18;
    localparam int TGT_W    = 52;
    localparam int OUT_W    = 88;

    localparam logic [4:0]  ROOT_TOP   = 5'd16;
    localparam logic [4:0]  FRAC_LAST  = 5'(LOG_FRAC - 1);
    localparam logic [5:0]  X_TOP_POS  = 6'(X_W - 1);
    localparam logic [24:0] DB_K       = 25'd19728302;
    localparam logic signed [31:0] LOG_OFFSET = 32'sd503316480;
    localparam logic signed [17:0] SILENT_DB  = -18'sd100000;

    localparam logic [2:0]  ADDR_WLEN  = 3'd0;
    localparam logic [2:0]  ADDR_CHCNT = 3'd4;
    localparam logic [15:0] WLEN_RESET  = 16'd10000;
    localparam logic [3:0]  CHCNT_RESET = 4'd2;

    typedef enum logic [4:0] {
        OP_NOP, OP_ACCUM, OP_LOAD, OP_NORM, OP_MANT, OP_SQ, OP_SQ_UPD, OP_LOG_SAVE,
        OP_DB_MUL, OP_DB_FIN, OP_ROOT_INIT, OP_ROOT_SQ, OP_RND_SQ, OP_ROOT_MN,
        OP_ROOT_CMP, OP_RND_CMP, OP_ROOT_SAVE, OP_EMIT
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOG_LOAD, ST_NORM, ST_MANT, ST_SQ, ST_SQ_UPD, ST_LOG_SAVE,
        ST_DB_MUL, ST_DB_FIN, ST_ROOT_INIT, ST_ROOT_SQ, ST_ROOT_MN, ST_ROOT_CMP,
        ST_RND_SQ, ST_RND_MN, ST_RND_CMP, ST_ROOT_SAVE, ST_EMIT
    } state_t;

    typedef struct packed {
        op_t        op;
        logic       sel;
        logic [4:0] idx;
    } cmd_t;

    typedef struct packed {
        logic win_end;
        logic sum_zero;
        logic x_top;
        logic out_free;
    } stat_t;

endpackage

>>> hw/rtl/wrpm_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine of the windowed rms power meter
module wrpm_ctrl import wrpm_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t     state_reg, state_next;
    logic [4:0] iter_reg, iter_next;
    logic       which_reg, which_next;
    logic       peak_reg, peak_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
            which_reg <= 1'b0;
            peak_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            which_reg <= which_next;
            peak_reg  <= peak_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        which_next = which_reg;
        peak_next  = peak_reg;
        cmd.op     = OP_NOP;
        cmd.sel    = 1'b0;
        cmd.idx    = iter_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op = OP_ACCUM;
                    if (stat.win_end) begin
                        state_next = ST_LOG_LOAD;
                        which_next = 1'b0;
                        peak_next  = 1'b0;
                    end
                end
            end
            ST_LOG_LOAD: begin
                // silent window skips both logarithms
                if (!which_reg && stat.sum_zero) begin
                    state_next = ST_DB_FIN;
                end else begin
                    cmd.op     = OP_LOAD;
                    cmd.sel    = which_reg;
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                cmd.op = OP_NORM;
                if (stat.x_top) state_next = ST_MANT;
            end
            ST_MANT: begin
                cmd.op     = OP_MANT;
                iter_next  = '0;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.op     = OP_SQ;
                state_next = ST_SQ_UPD;
            end
            ST_SQ_UPD: begin
                cmd.op    = OP_SQ_UPD;
                iter_next = iter_reg + 5'd1;
                if (iter_reg == FRAC_LAST) state_next = ST_LOG_SAVE;
                else state_next = ST_SQ;
            end
            ST_LOG_SAVE: begin
                cmd.op  = OP_LOG_SAVE;
                cmd.sel = which_reg;
                if (!which_reg) begin
                    which_next = 1'b1;
                    state_next = ST_LOG_LOAD;
                end else begin
                    state_next = ST_DB_MUL;
                end
            end
            ST_DB_MUL: begin
                cmd.op     = OP_DB_MUL;
                state_next = ST_DB_FIN;
            end
            ST_DB_FIN: begin
                cmd.op     = OP_DB_FIN;
                state_next = ST_ROOT_INIT;
            end
            ST_ROOT_INIT: begin
                cmd.op     = OP_ROOT_INIT;
                cmd.sel    = peak_reg;
                iter_next  = ROOT_TOP;
                state_next = ST_ROOT_SQ;
            end
            ST_ROOT_SQ: begin
                cmd.op     = OP_ROOT_SQ;
                state_next = ST_ROOT_MN;
            end
            ST_ROOT_MN: begin
                cmd.op     = OP_ROOT_MN;
                state_next = ST_ROOT_CMP;
            end
            ST_ROOT_CMP: begin
                cmd.op = OP_ROOT_CMP;
                if (iter_reg == 5'd0) begin
                    state_next = ST_RND_SQ;
                end else begin
                    iter_next  = iter_reg - 5'd1;
                    state_next = ST_ROOT_SQ;
                end
            end
            ST_RND_SQ: begin
                cmd.op     = OP_RND_SQ;
                state_next = ST_RND_MN;
            end
            ST_RND_MN: begin
                cmd.op     = OP_ROOT_MN;
                state_next = ST_RND_CMP;
            end
            ST_RND_CMP: begin
                cmd.op     = OP_RND_CMP;
                state_next = ST_ROOT_SAVE;
            end
            ST_ROOT_SAVE: begin
                cmd.op  = OP_ROOT_SAVE;
                cmd.sel = peak_reg;
                if (!peak_reg) begin
                    peak_next  = 1'b1;
                    state_next = ST_ROOT_INIT;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/wrpm_dp.sv
`timescale 1ns / 1ps
// accumulator, log, root and output registers of the windowed rms power meter
module wrpm_dp import wrpm_pkg::*; #(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cmd_t                   cmd,
    output stat_t                  stat,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [15:0]            window_length,
    input  logic [3:0]             channel_count,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_W-1:0]       m_tdata
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic signed [15:0] samp16;
    logic signed [31:0] sq_s;
    logic [SUM_W:0]     sum_add;
    logic [4:0]         ch_eff, cc_ext;
    logic [15:0]        wl_eff;
    logic               ch_last, fr_last;

    logic [SUM_W-1:0]   sum_reg;
    logic [CH_W-1:0]    ch_pos_reg;
    logic [15:0]        fr_pos_reg;
    logic [31:0]        base_reg;
    logic [N_W-1:0]     n_reg;
    logic [15:0]        wl_reg;

    logic [X_W-1:0]     x_reg;
    logic [5:0]         e_reg;
    logic [31:0]        m_reg;
    logic [LOG_FRAC-1:0] frac_reg;
    logic [LOG_W-1:0]   ls_reg, ln_reg;
    logic [63:0]        prod_reg;
    logic               dpos_reg;
    logic [ROOT_W-1:0]  r_reg, t_reg;
    logic [TGT_W-1:0]   target_reg;

    logic               m_valid_reg;
    logic [31:0]        out_base_reg;
    logic signed [17:0] db_reg;
    logic [15:0]        rms_reg, peak_reg;
    logic signed [17:0] out_db_reg;
    logic [15:0]        out_rms_reg, out_peak_reg;

    logic [35:0]        mul_a;
    logic [31:0]        mul_b;
    logic [67:0]        mul_p;
    logic [ROOT_W-1:0]  t_root, t_rnd;
    logic [32:0]        mm;
    logic signed [31:0] d;
    logic [29:0]        negd;
    logic [55:0]        c_round;
    logic [15:0]        root_sat;

    // sample brought to 16 bits
    generate
        if (SAMPLE_BITS >= 16) begin : g_wide
            assign samp16 = sample[SAMPLE_BITS-1 -: 16];
        end else begin : g_narrow
            assign samp16 = {sample, {(16 - SAMPLE_BITS){1'b0}}};
        end
    endgenerate

    assign sq_s    = samp16 * samp16;
    assign sum_add = {1'b0, sum_reg} + {19'b0, sq_s};

    assign cc_ext = {1'b0, channel_count};
    always_comb begin
        if (cc_ext == 5'd0) ch_eff = 5'd1;
        else if (cc_ext > 5'(MAX_CHANNELS)) ch_eff = 5'(MAX_CHANNELS);
        else ch_eff = cc_ext;
    end
    assign wl_eff  = (window_length == 16'd0) ? 16'd1 : window_length;
    assign ch_last = (5'(ch_pos_reg) + 5'd1) >= ch_eff;
    assign fr_last = (17'(fr_pos_reg) + 17'd1) >= {1'b0, wl_eff};

    assign stat.win_end  = ch_last & fr_last;
    assign stat.sum_zero = (sum_reg == '0);
    assign stat.x_top    = x_reg[X_W-1];
    assign stat.out_free = !m_valid_reg || m_tready;

    // one shared multiplier, operands picked by the command
    assign t_root = r_reg | (ROOT_W'(1) << cmd.idx);
    assign t_rnd  = {r_reg[ROOT_W-2:0], 1'b1};
    always_comb begin
        case (cmd.op)
            OP_SQ: begin
                mul_a = {4'b0, m_reg};
                mul_b = m_reg;
            end
            OP_ROOT_SQ: begin
                mul_a = {18'b0, t_root};
                mul_b = {14'b0, t_root};
            end
            OP_RND_SQ: begin
                mul_a = {18'b0, t_rnd};
                mul_b = {14'b0, t_rnd};
            end
            OP_ROOT_MN: begin
                mul_a = prod_reg[35:0];
                mul_b = {11'b0, n_reg};
            end
            OP_DB_MUL: begin
                mul_a = {6'b0, negd};
                mul_b = {7'b0, DB_K};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign mm       = prod_reg[63:31];
    assign d        = $signed({2'b0, ls_reg}) - $signed({2'b0, ln_reg}) - LOG_OFFSET;
    assign negd     = 30'(-d);
    assign c_round  = {1'b0, prod_reg[54:0]} + (56'd1 << 39);
    assign root_sat = (r_reg > ROOT_W'(16'hffff)) ? 16'hffff : r_reg[15:0];

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            ch_pos_reg  <= '0;
            fr_pos_reg  <= '0;
            base_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_tready) m_valid_reg <= 1'b0;
            case (cmd.op)
                OP_ACCUM: begin
                    sum_reg <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                    if (ch_last) begin
                        ch_pos_reg <= '0;
                        if (fr_last) fr_pos_reg <= '0;
                        else fr_pos_reg <= fr_pos_reg + 16'd1;
                    end else begin
                        ch_pos_reg <= ch_pos_reg + CH_W'(1);
                    end
                end
                OP_EMIT: begin
                    m_valid_reg <= 1'b1;
                    sum_reg     <= '0;
                    if (base_reg > (32'hffffffff - {16'b0, wl_reg})) base_reg <= '1;
                    else base_reg <= base_reg + {16'b0, wl_reg};
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_ACCUM: begin
                if (ch_last && fr_last) begin
                    n_reg  <= N_W'({5'b0, wl_eff} * {16'b0, ch_eff});
                    wl_reg <= wl_eff;
                end
            end
            OP_LOAD: begin
                x_reg <= cmd.sel ? {(X_W - N_W)'(0), n_reg} : {1'b0, sum_reg};
                e_reg <= X_TOP_POS;
            end
            OP_NORM: begin
                if (!x_reg[X_W-1]) begin
                    x_reg <= {x_reg[X_W-2:0], 1'b0};
                    e_reg <= e_reg - 6'd1;
                end
            end
            OP_MANT: begin
                m_reg    <= x_reg[X_W-1 -: 32];
                frac_reg <= '0;
            end
            OP_SQ, OP_ROOT_MN: prod_reg <= mul_p[63:0];
            OP_SQ_UPD: begin
                frac_reg <= {frac_reg[LOG_FRAC-2:0], mm[32]};
                m_reg    <= mm[32] ? mm[32:1] : mm[31:0];
            end
            OP_LOG_SAVE: begin
                if (cmd.sel) ln_reg <= {e_reg, frac_reg};
                else ls_reg <= {e_reg, frac_reg};
            end
            OP_DB_MUL: begin
                prod_reg <= mul_p[63:0];
                dpos_reg <= !d[31];
            end
            OP_DB_FIN: begin
                if (sum_reg == '0) db_reg <= SILENT_DB;
                else if (dpos_reg) db_reg <= '0;
                else db_reg <= -$signed({2'b0, c_round[55:40]});
            end
            OP_ROOT_INIT: begin
                r_reg      <= '0;
                target_reg <= cmd.sel ? {1'b0, sum_reg, 1'b0} : {2'b0, sum_reg};
            end
            OP_ROOT_SQ: begin
                t_reg    <= t_root;
                prod_reg <= mul_p[63:0];
            end
            OP_RND_SQ: begin
                t_reg    <= t_rnd;
                prod_reg <= mul_p[63:0];
            end
            OP_ROOT_CMP: begin
                if (prod_reg <= {12'b0, target_reg}) r_reg <= t_reg;
            end
            OP_RND_CMP: begin
                if (prod_reg <= {10'b0, target_reg, 2'b0}) r_reg <= r_reg + ROOT_W'(1);
            end
            OP_ROOT_SAVE: begin
                if (cmd.sel) peak_reg <= root_sat;
                else rms_reg <= root_sat;
            end
            // results held here while the next window is being worked on
            OP_EMIT: begin
                out_base_reg <= base_reg;
                out_db_reg   <= db_reg;
                out_rms_reg  <= rms_reg;
                out_peak_reg <= peak_reg;
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, out_peak_reg, out_rms_reg, out_db_reg, out_base_reg};

endmodule

>>> hw/rtl/windowed_rms_power_meter.sv
`timescale 1ns / 1ps
// windowed rms power meter: sample stream in, one level request per window out
// throughput: one sample per cycle within a window; the sample that closes a window
// stalls the input for the end-of-window math: two bit-serial log2 runs, two 17-step
// root searches on the shared multiplier, dB and emit steps; a silent window skips the
// log runs. m_tvalid rises once that math is done, later while an earlier result
// still waits in the output register
// reset: aresetn synchronous active low, clears sums, positions, window base, output valid
module windowed_rms_power_meter import wrpm_pkg::*; #(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    localparam int SDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    // sample stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [SDATA_W-1:0] s_tdata,   // sample
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata,   // window_start, power_centi_db, rms_level, peak_level
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0] wlen_reg;
    logic [3:0]  chcnt_reg;
    logic        cfg_wr;
    cmd_t        cmd;
    stat_t       stat;

    // register file: window length at 0, channel count at 4
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg  <= WLEN_RESET;
            chcnt_reg <= CHCNT_RESET;
        end else if (cfg_wr) begin
            if (paddr == ADDR_WLEN) wlen_reg <= pwdata[15:0];
            if (paddr == ADDR_CHCNT) chcnt_reg <= pwdata[3:0];
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_WLEN:  prdata = {16'b0, wlen_reg};
            ADDR_CHCNT: prdata = {28'b0, chcnt_reg};
            default:    prdata = '0;
        endcase
    end

    // sequencer steps the datapath through accumulate, log, dB, roots, emit
    wrpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wrpm_dp #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .sample        (s_tdata[SAMPLE_BITS-1:0]),
        .window_length (wlen_reg),
        .channel_count (chcnt_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

>>> hw/rtl/wrpm_chk.sv
`timescale 1ns / 1ps
// port checker of the windowed rms power meter with its bind
module wrpm_chk import wrpm_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result request dropped or changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_peak_ge_rms: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[81:66] >= m_tdata[65:50])
        else $error("peak below rms");

    a_db_nonpos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[49] || (m_tdata[49:32] == 18'd0))
        else $error("positive power reading");

endmodule

bind windowed_rms_power_meter wrpm_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> verif/windowed_rms_power_meter_test.sv
`timescale 1ns / 1ps
// testbench for the windowed rms power meter: directed and random samples checked against a predictor
module windowed_rms_power_meter_test;
    import wrpm_pkg::*;

    // cycles without any accepted request before the run is declared hung
    localparam int STALL_LIMIT = 20000;
    // end-of-window math plus output register, with margin
    localparam int SETTLE_CYCLES = 400;
    localparam int LONG_HOLD = 3000;

    typedef struct packed {
        logic [31:0]        window_start;
        logic signed [17:0] power_centi_db;
        logic [15:0]        rms_level;
        logic [15:0]        peak_level;
    } level_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata = '0;    // sample
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;         // window_start, power_centi_db, rms_level, peak_level
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    windowed_rms_power_meter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // predictor state: registers and window accumulation
    logic [15:0]         cfg_wlen = WLEN_RESET;
    logic [3:0]          cfg_chans = CHCNT_RESET;
    longint unsigned     pwr_sum = 0;
    int unsigned         chan_pos = 0;
    int unsigned         frame_pos = 0;
    logic [31:0]         base_frame = 0;
    level_t              pending_levels[$];

    int                  error_count = 0;
    int                  sender_idle_pct = 0;
    int                  receiver_stall_pct = 0;
    bit                  hold_request = 0;
    int                  hold_left = 0;
    int                  quiet_cycles = 0;

    // largest r with r*r*n <= s, rounded to nearest with ties up, clipped to 16 bits
    function automatic longint unsigned root_nearest(longint unsigned s, longint unsigned n);
        longint unsigned r, t;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t * n <= s) r = t;
        end
        if (4 * s >= (2 * r + 1) * (2 * r + 1) * n) r++;
        return (r > 65535) ? 65535 : r;
    endfunction

    // log2 in q.24 by repeated squaring of a q1.31 mantissa
    function automatic longint log2_fixed(longint unsigned x);
        int e;
        longint unsigned m, frac;
        e = 63;
        frac = 0;
        while (e > 0 && !x[e]) e--;
        m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
        for (int i = 0; i < LOG_FRAC; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32)) begin
                frac |= 1;
                m = m >> 1;
            end
        end
        return (longint'(e) << LOG_FRAC) | longint'(frac);
    endfunction

    function automatic logic signed [17:0] power_db(longint unsigned s, longint unsigned n);
        longint d;
        longint unsigned c;
        if (s == 0) return SILENT_DB;
        d = log2_fixed(s) - log2_fixed(n) - (longint'(30) << LOG_FRAC);
        if (d >= 0) return 18'sd0;
        c = (longint'(-d) * 64'd19728302 + (64'd1 << 39)) >> 40;
        if (c > 131072) c = 131072;
        return -18'(c);
    endfunction

    // accumulate one accepted sample and queue the level a closed window yields
    task automatic meter_sample(logic signed [15:0] smp);
        longint v;
        longint unsigned sq, n, sum_max;
        int unsigned ch, wl;
        level_t lv;
        v = smp;
        sq = v * v;
        sum_max = (64'd1 << 50) - 1;
        ch = (cfg_chans < 1) ? 1 : (cfg_chans > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : cfg_chans;
        wl = (cfg_wlen < 1) ? 1 : cfg_wlen;
        pwr_sum = (pwr_sum > sum_max - sq) ? sum_max : pwr_sum + sq;
        if (chan_pos + 1 < ch) begin
            chan_pos++;
            return;
        end
        chan_pos = 0;
        if (frame_pos + 1 < wl) begin
            frame_pos++;
            return;
        end
        n = longint'(wl) * ch;
        lv.window_start = base_frame;
        lv.power_centi_db = power_db(pwr_sum, n);
        lv.rms_level = 16'(root_nearest(pwr_sum, n));
        lv.peak_level = 16'(root_nearest(pwr_sum * 2, n));
        pending_levels.push_back(lv);
        base_frame = (base_frame > 32'hFFFF_FFFF - wl) ? 32'hFFFF_FFFF : base_frame + wl;
        pwr_sum = 0;
        frame_pos = 0;
    endtask

    // offer one sample, with a random gap before it
    task automatic send_sample(logic [15:0] smp);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        meter_sample(smp);
    endtask

    // apb write: setup then access, register updates at the access edge
    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        s_tvalid <= 1'b0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (addr == ADDR_WLEN) cfg_wlen = value[15:0];
        else if (addr == ADDR_CHCNT) cfg_chans = value[3:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // wait until all queued levels are out, then let any window math finish
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_levels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_window(int unsigned wl, int unsigned ch);
        drain();
        reg_write(ADDR_WLEN, wl);
        reg_write(ADDR_CHCNT, ch);
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(64)) - 32);
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // full-scale, zero and unit samples, out-of-range registers, above-full-scale window
    task automatic test_directed;
        set_window(1, 1);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        // channel count zero acts as one
        set_window(1, 0);
        send_sample(16'h1234);
        // zero length and channel count above max
        set_window(0, 15);
        for (int i = 0; i < 8; i++) send_sample(16'(i * 4099));
        set_window(2, 8);
        for (int i = 0; i < 16; i++) send_sample(16'h0000);
        // longest window left open, then shortened so the sum exceeds full scale
        set_window(65535, 1);
        repeat (3) send_sample(16'h8000);
        set_window(1, 1);
        send_sample(16'h8000);
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_backpressure;
        set_window(1, 1);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_request = 1;
        repeat (20) send_sample(random_sample());
    endtask

    // random windows and samples under one idling mix
    task automatic test_random(int idle_pct, int stall_pct, int samples);
        int sent;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        sent = 0;
        while (sent < samples) begin
            if ($urandom_range(9) == 0) set_window($urandom_range(40, 1), $urandom_range(15));
            else set_window($urandom_range(6, 1), $urandom_range(9, 1));
            repeat ($urandom_range(80, 20)) begin
                send_sample(random_sample());
                sent++;
            end
        end
    endtask

    // receiver: random stalls, or a long hold counted here
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // result checker against the oldest queued level
    always @(posedge aclk) begin
        level_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.window_start = m_tdata[31:0];
            got.power_centi_db = m_tdata[49:32];
            got.rms_level = m_tdata[65:50];
            got.peak_level = m_tdata[81:66];
            if (pending_levels.size() == 0) begin
                $error("unexpected result request window_start %0d", got.window_start);
                error_count++;
            end else begin
                want = pending_levels.pop_front();
                if (got.window_start !== want.window_start) begin
                    $error("window_start expected %0d got %0d", want.window_start,
                           got.window_start);
                    error_count++;
                end
                if (got.power_centi_db !== want.power_centi_db) begin
                    $error("power_centi_db expected %0d got %0d", want.power_centi_db,
                           got.power_centi_db);
                    error_count++;
                end
                if (got.rms_level !== want.rms_level) begin
                    $error("rms_level expected %0d got %0d", want.rms_level, got.rms_level);
                    error_count++;
                end
                if (got.peak_level !== want.peak_level) begin
                    $error("peak_level expected %0d got %0d", want.peak_level, got.peak_level);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no request moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random(0, 0, 460);
        test_random(68, 0, 460);
        test_random(0, 68, 460);
        test_random(37, 37, 460);
        drain();
        if (pending_levels.size() != 0) begin
            $error("%0d expected results never arrived", pending_levels.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
